// File: rtl/fis_pkg.sv
package fis_pkg;

  localparam int unsigned HistDepth = 64;
  localparam int unsigned IdxW = $clog2(HistDepth);
  localparam int unsigned CntW = $clog2(HistDepth + 1);
  localparam int unsigned SumW = 24 + CntW;

  localparam logic [23:0] RingPreset = 24'd16667;
  localparam logic [SumW-1:0] SumPreset = SumW'(64'd16667 * HistDepth);
  localparam logic [27:0] FpsMax = 28'hFFFFFFF;
  localparam logic [27:0] FpsReset = 28'd15360;
  localparam logic [27:0] FpsNum = 28'd256000000;
  localparam int unsigned StableMin = 10;
  localparam int unsigned StatsFrame = 5;

  localparam int unsigned QW = 2 * (SumW + CntW) + IdxW + 1;
  localparam int unsigned CmpW = QW + 14;
  localparam int unsigned DivNW = 28 + CntW;

  typedef enum logic [1:0] {
    CfgMaxDelta  = 2'd0,
    CfgTimeScale = 2'd1,
    CfgThreshold = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic        mode;
    logic [23:0] frame_delta_us;
  } fis_in_t;

  typedef struct packed {
    logic [23:0] clamped_delta_us;
    logic [23:0] scaled_delta_us;
    logic [47:0] total_time_us;
    logic [31:0] frame_total;
    logic [27:0] fps_now;
    logic [27:0] fps_average;
    logic [27:0] fps_lowest;
    logic [27:0] fps_highest;
    logic        rate_stable;
  } fis_out_t;

  typedef struct packed {
    logic [1:0]  idx;
    logic [31:0] data;
  } fis_cfg_t;

endpackage

// File: rtl/frame_interval_statistics.sv
// Moving-window frame rate monitor. Each frame tick runs up to two divisions
// on one shared restoring divider (a zero interval skips the first, a zero
// window sum the second), then a walk over the filled entries of the 64-entry
// interval ring through one shared multiplier, and final products on that
// multiplier for the stability flag. A statistics reset (mode 1) skips the
// divisions. The walk and the final products are skipped while fewer than 10
// intervals have been taken. After reset, a clearing pass fills the ring with
// 16667 us before the first transaction is accepted. Mode 1 clears min/max FPS and copies fps_now into the average.
module frame_interval_statistics (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fis_pkg::fis_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fis_pkg::fis_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  fis_pkg::fis_cfg_t cfg_data_i
);
  import fis_pkg::*;

  typedef enum logic [3:0] {
    StClear, StIdle, StRdOld, StWrite, StDivFps, StWaitFps, StDivAvg, StWaitAvg,
    StStabInit, StRead, StMulA, StMulB, StFinal, StOut
  } state_e;

  typedef enum logic [2:0] {
    FinThr, FinCnt, FinSum, FinRhsLo, FinRhsHi, FinLhs0, FinLhs1, FinLhs2
  } fin_e;

  state_e state_q;
  fin_e   fin_q;

  logic [23:0] max_delta_q, hist_wdata, hist_rdata;
  logic [15:0] time_scale_q;
  logic [9:0]  thr_q;
  logic [IdxW-1:0] ring_idx_q, clr_q, walk_q, raddr, waddr;
  logic        filled_q, hist_we;
  logic [SumW-1:0] wsum_q;
  logic [47:0] total_q;
  logic [31:0] frames_q;
  logic [27:0] fps_q, avg_q, min_q, max_q;
  logic [23:0] delta_q;
  logic        stable_q, out_valid_q;
  logic [QW-1:0] acc_q;
  logic [SumW-1:0] diff_q, k_q;
  logic [2*SumW-1:0] prod_q;
  logic [CmpW-1:0] lhs_q, rhs_q;
  logic        walk_last_q;

  logic [SumW-1:0]   mul_a, mul_b;
  logic [2*SumW-1:0] mul_p;

  logic              div_start, div_done;
  logic [DivNW-1:0]  div_num, div_quot;
  logic [SumW-1:0]   div_den;

  logic [23:0] dclamp;
  logic [CntW-1:0] cnt;
  logic [39:0] scaled_full;

  assign dclamp = (in_data_i.frame_delta_us < max_delta_q) ?
                  in_data_i.frame_delta_us : max_delta_q;
  assign cnt = filled_q ? CntW'(HistDepth) : CntW'(ring_idx_q);

  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign hist_we     = (state_q == StClear) || (state_q == StWrite);
  assign waddr       = (state_q == StClear) ? clr_q : ring_idx_q;
  assign hist_wdata  = (state_q == StClear) ? RingPreset : delta_q;
  assign raddr       = (state_q == StRdOld || state_q == StIdle) ? ring_idx_q : walk_q;

  fis_ram #(.Width(24), .Depth(HistDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (waddr),
    .wdata_i (hist_wdata),
    .raddr_i (raddr),
    .rdata_o (hist_rdata)
  );

  assign div_start = (state_q == StDivFps) || (state_q == StDivAvg);
  assign div_num = (state_q == StDivFps) ?
                   DivNW'({4'd0, FpsNum} + {28'd0, delta_q[23:1]}) :
                   DivNW'(cnt * FpsNum) + DivNW'(wsum_q >> 1);
  assign div_den = (state_q == StDivFps) ? SumW'(delta_q) : wsum_q;

  fis_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  logic [27:0] quot_sat;
  assign quot_sat = (div_quot > DivNW'(FpsMax)) ? FpsMax : div_quot[27:0];

  // shared multiplier: n*h and squares during the walk, then the final products
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == StMulA) begin
      mul_a = SumW'(cnt);
      mul_b = SumW'(hist_rdata);
    end else if (state_q == StMulB) begin
      mul_a = diff_q;
      mul_b = diff_q;
    end else if (state_q == StFinal) begin
      unique case (fin_q)
        FinThr: begin
          mul_a = SumW'(thr_q);
          mul_b = SumW'(thr_q);
        end
        FinCnt: begin
          mul_a = k_q;
          mul_b = SumW'(cnt);
        end
        FinSum: begin
          mul_a = wsum_q;
          mul_b = wsum_q;
        end
        FinRhsLo: begin
          mul_a = prod_q[SumW-1:0];
          mul_b = k_q;
        end
        FinRhsHi: begin
          mul_a = prod_q[2*SumW-1:SumW];
          mul_b = k_q;
        end
        FinLhs0: begin
          mul_a = acc_q[SumW-1:0];
          mul_b = SumW'(14'd10000);
        end
        FinLhs1: begin
          mul_a = acc_q[2*SumW-1:SumW];
          mul_b = SumW'(14'd10000);
        end
        FinLhs2: begin
          mul_a = SumW'(acc_q[QW-1:2*SumW]);
          mul_b = SumW'(14'd10000);
        end
        default: ;
      endcase
    end
  end
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      fin_q        <= FinThr;
      clr_q        <= '0;
      max_delta_q  <= 24'd50000;
      time_scale_q <= 16'd256;
      thr_q        <= 10'd5;
      ring_idx_q   <= '0;
      filled_q     <= 1'b0;
      wsum_q       <= SumPreset;
      total_q      <= '0;
      frames_q     <= '0;
      fps_q        <= FpsReset;
      avg_q        <= FpsReset;
      min_q        <= FpsMax;
      max_q        <= '0;
      delta_q      <= '0;
      out_valid_q  <= 1'b0;
      stable_q     <= 1'b0;
      walk_q       <= '0;
      walk_last_q  <= 1'b0;
      acc_q        <= '0;
      diff_q       <= '0;
      k_q          <= '0;
      prod_q       <= '0;
      lhs_q        <= '0;
      rhs_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_data_i.idx)
          CfgMaxDelta:  max_delta_q  <= cfg_data_i.data[23:0];
          CfgTimeScale: time_scale_q <= cfg_data_i.data[15:0];
          CfgThreshold: thr_q        <= cfg_data_i.data[9:0];
          default: ;
        endcase
      end
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == IdxW'(HistDepth - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (in_valid_i) begin
            if (!in_data_i.mode) begin
              delta_q  <= dclamp;
              total_q  <= total_q + 48'(dclamp);
              frames_q <= frames_q + 1'b1;
              state_q  <= StRdOld;
            end else begin
              min_q   <= FpsMax;
              max_q   <= '0;
              avg_q   <= fps_q;
              state_q <= StStabInit;
            end
          end
        end
        StRdOld: state_q <= StWrite;
        StWrite: begin
          wsum_q     <= wsum_q - SumW'(hist_rdata) + SumW'(delta_q);
          ring_idx_q <= (ring_idx_q == IdxW'(HistDepth - 1)) ? '0 : ring_idx_q + 1'b1;
          if (ring_idx_q == IdxW'(HistDepth - 1)) filled_q <= 1'b1;
          state_q <= (delta_q != '0) ? StDivFps : StWaitFps;
        end
        StDivFps: state_q <= StWaitFps;
        StWaitFps: begin
          if (div_done || delta_q == '0) begin
            logic [27:0] f;
            f = (delta_q != '0) ? quot_sat : fps_q;
            fps_q <= f;
            if (frames_q > 32'(StatsFrame)) begin
              if (f < min_q) min_q <= f;
              if (f > max_q) max_q <= f;
            end
            state_q <= (wsum_q != '0) ? StDivAvg : StStabInit;
          end
        end
        StDivAvg: state_q <= StWaitAvg;
        StWaitAvg: begin
          if (div_done) begin
            avg_q   <= quot_sat;
            state_q <= StStabInit;
          end
        end
        StStabInit: begin
          acc_q  <= '0;
          walk_q <= '0;
          fin_q  <= FinThr;
          if (!filled_q && ring_idx_q < IdxW'(StableMin)) begin
            stable_q <= 1'b1;
            state_q  <= StOut;
          end else if (wsum_q == '0) begin
            stable_q <= 1'b0;
            state_q  <= StOut;
          end else begin
            state_q <= StRead;
          end
        end
        StRead: begin
          walk_last_q <= (CntW'(walk_q) == cnt - 1'b1);
          walk_q      <= walk_q + 1'b1;
          state_q     <= StMulA;
        end
        StMulA: begin
          diff_q  <= (mul_p[SumW-1:0] >= wsum_q) ? mul_p[SumW-1:0] - wsum_q :
                     wsum_q - mul_p[SumW-1:0];
          state_q <= StMulB;
        end
        StMulB: begin
          acc_q   <= acc_q + QW'(mul_p);
          state_q <= walk_last_q ? StFinal : StRead;
        end
        StFinal: begin
          fin_q <= fin_e'(fin_q + 1'b1);
          unique case (fin_q) inside
            FinThr, FinCnt: k_q <= mul_p[SumW-1:0];
            FinSum:   prod_q <= mul_p;
            FinRhsLo: rhs_q  <= CmpW'(mul_p);
            FinRhsHi: rhs_q  <= rhs_q + (CmpW'(mul_p) << SumW);
            FinLhs0:  lhs_q  <= CmpW'(mul_p);
            FinLhs1:  lhs_q  <= lhs_q + (CmpW'(mul_p) << SumW);
            FinLhs2: begin
              lhs_q   <= lhs_q + (CmpW'(mul_p) << (2 * SumW));
              state_q <= StOut;
            end
            default: ;
          endcase
        end
        StOut: begin
          if (!out_valid_q) out_valid_q <= 1'b1;
          else if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // final compare, in the cycle after the last product
  logic            final_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) final_q <= 1'b0;
    else final_q <= (state_q == StFinal) && (fin_q == FinLhs2);
  end

  logic stable_out;
  logic stab_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) stab_q <= 1'b1;
    else if (final_q) stab_q <= (lhs_q <= rhs_q);
    else if (state_q == StStabInit) stab_q <= 1'b0;
  end
  logic walked_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) walked_q <= 1'b0;
    else if (state_q == StStabInit) walked_q <= 1'b0;
    else if (state_q == StFinal) walked_q <= 1'b1;
  end
  assign stable_out = walked_q ? stab_q : stable_q;

  assign scaled_full = delta_q * time_scale_q;
  assign out_valid_o = out_valid_q && !final_q;
  always_comb begin
    out_data_o.clamped_delta_us = delta_q;
    out_data_o.scaled_delta_us  = (scaled_full[39:32] != '0) ? 24'hFFFFFF :
                                  scaled_full[31:8];
    out_data_o.total_time_us    = total_q;
    out_data_o.frame_total      = frames_q;
    out_data_o.fps_now          = fps_q;
    out_data_o.fps_average      = avg_q;
    out_data_o.fps_lowest       = min_q;
    out_data_o.fps_highest      = max_q;
    out_data_o.rate_stable      = stable_out;
  end

endmodule

// File: rtl/fis_ram.sv
module fis_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/fis_div.sv
module fis_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [fis_pkg::DivNW-1:0] num_i,
  input  logic [fis_pkg::SumW-1:0]  den_i,
  output logic                      done_o,
  output logic [fis_pkg::DivNW-1:0] quot_o
);
  import fis_pkg::*;

  localparam int unsigned StepW = $clog2(DivNW + 1);

  logic [DivNW-1:0] num_q, num_d, quot_q, quot_d;
  logic [SumW:0]    rem_q, rem_d, trial;
  logic [SumW-1:0]  den_q, den_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d, done_q, done_d;

  always_comb begin
    num_d  = num_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[SumW-1:0], num_q[DivNW-1]};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quot_d = '0;
      step_d = StepW'(DivNW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[DivNW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[DivNW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[DivNW-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
